// ===== rtl/lgssp_pkg.sv =====
// ----------------------------------------------------------------------------
// lgssp_pkg
// Shared constants, types and helpers for the landmine grid safe route block.
// ----------------------------------------------------------------------------
package lgssp_pkg;

   // Field size limits
   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

   // Widths derived from the limits
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
   localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int ENTRY_W    = ROW_W + COL_W;

   // Fixed interface widths
   localparam int CFG_W      = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int LEN_W      = 10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   // Neighbor selector codes
   localparam int DIR_W = 3;
   localparam logic [DIR_W-1:0] DIR_SELF  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SF_RD,
      ST_SF_CHK,
      ST_SEED_RD,
      ST_SEED_CHK,
      ST_POP,
      ST_POP_WAIT,
      ST_POP_MUL,
      ST_NB_RD,
      ST_NB_CHK,
      ST_DONE
   } state_type;

   // Clamp a row count register to 1..MAX_ROWS
   function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
      logic [ROW_CNT_W-1:0] r;
      if (v == '0) r = ROW_CNT_W'(1);
      else if (int'(v) > MAX_ROWS) r = ROW_CNT_W'(MAX_ROWS);
      else r = ROW_CNT_W'(v);
      return r;
   endfunction

   // Clamp a column count register to 1..MAX_COLS
   function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
      logic [COL_CNT_W-1:0] r;
      if (v == '0) r = COL_CNT_W'(1);
      else if (int'(v) > MAX_COLS) r = COL_CNT_W'(MAX_COLS);
      else r = COL_CNT_W'(v);
      return r;
   endfunction

endpackage

// ===== rtl/landmine_grid_shortest_safe_path_top.sv =====
// ----------------------------------------------------------------------------
// landmine_grid_shortest_safe_path_top
// Loads a mine field cell by cell, then finds the shortest safe route from
// the first to the last column with a breadth-first walk.
// ----------------------------------------------------------------------------
// Cells load at one per cycle into the field memory while the block is idle
// and no configuration write is offered. After the last cell the block is
// busy (req_ready low) while one small sequencer works through three phases
// over memories with one write and one registered read port: a safety pass
// (five neighbor reads of the field memory, each with a registered read),
// which also rewrites the visited map, marking unsafe cells as visited and
// clearing the rest; a seeding pass, one row at a time; and the walk itself,
// which dequeues each cell and then reads each of its neighbors, with a step
// per level and a final empty check, then hands the result over. The field
// memory read port bounds the safety pass. Configuration writes are taken
// only while the block is idle and restart the load; the cell channel holds
// off while a write is offered.
// ----------------------------------------------------------------------------
module landmine_grid_shortest_safe_path_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cell_open,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_route_found,
   output logic [lgssp_pkg::LEN_W-1:0]     rsp_route_length,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lgssp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lgssp_pkg::CFG_W-1:0]     csr_data
);
   import lgssp_pkg::*;

   // Memories
   logic mine_mem [CELL_COUNT];
   logic seen_mem [CELL_COUNT];
   logic [ENTRY_W-1:0] queue_mem [CELL_COUNT];

   state_type state_ff, state_in;
   logic [CFG_W-1:0]     rows_ff, rows_in, cols_ff, cols_in;
   logic [CNT_W-1:0]     load_cnt_ff, load_cnt_in;
   logic [ROW_W-1:0]     cur_r_ff, cur_r_in, nb_r_ff, nb_r_in;
   logic [COL_W-1:0]     cur_c_ff, cur_c_in, nb_c_ff, nb_c_in;
   logic [CELL_W-1:0]    cur_idx_ff, cur_idx_in, nb_idx_ff, nb_idx_in;
   logic [DIR_W-1:0]     dir_ff, dir_in;
   logic                 unsafe_ff, unsafe_in;
   logic                 nb_ok_ff, nb_ok_in;
   logic [CNT_W-1:0]     head_ff, head_in, tail_ff, tail_in, lvl_end_ff, lvl_end_in;
   logic [LEN_W-1:0]     level_ff, level_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic                 mine_rd_ff, seen_rd_ff;
   logic [ENTRY_W-1:0]   queue_rd_ff;

   // Memory port controls
   logic                 mine_we, seen_we, seen_wdata, queue_we;
   logic [CELL_W-1:0]    mine_raddr, seen_waddr, seen_raddr, queue_waddr, queue_raddr;
   logic [ENTRY_W-1:0]   queue_wdata;

   // Effective field size
   logic [ROW_CNT_W-1:0] nr;
   logic [COL_CNT_W-1:0] nc;
   logic [CNT_W-1:0]     total;
   logic                 req_acc, csr_acc, rsp_free;
   logic                 last_col, last_row, last_cell;
   logic                 nb_inf;
   logic [CELL_W-1:0]    nb_idx;
   logic [ROW_W-1:0]     nb_r;
   logic [COL_W-1:0]     nb_c;
   logic                 unsafe_now, queue_room;

   assign nr        = clamp_rows(rows_ff);
   assign nc        = clamp_cols(cols_ff);
   assign total     = CNT_W'(CNT_W'(nr) * CNT_W'(nc));
   assign req_ready = (state_ff == ST_IDLE) & ~csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign csr_acc   = csr_valid & csr_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign last_col  = (COL_CNT_W'(cur_c_ff) + COL_CNT_W'(1)) == nc;
   assign last_row  = (ROW_CNT_W'(cur_r_ff) + ROW_CNT_W'(1)) == nr;
   assign last_cell = last_col & last_row;
   // a neighbor read in the safety pass flags a mine
   assign unsafe_now = unsafe_ff | (nb_ok_ff & ~mine_rd_ff);
   assign queue_room = tail_ff < CNT_W'(CELL_COUNT);

   // Neighbor of the current cell selected by dir_ff
   always_comb begin
      nb_inf = 1'b1;
      nb_idx = cur_idx_ff;
      nb_r   = cur_r_ff;
      nb_c   = cur_c_ff;
      case (dir_ff)
         DIR_SELF: begin
            nb_inf = 1'b1;
         end
         DIR_UP: begin
            nb_inf = (cur_r_ff != '0);
            nb_idx = cur_idx_ff - CELL_W'(nc);
            nb_r   = cur_r_ff - ROW_W'(1);
         end
         DIR_DOWN: begin
            nb_inf = (ROW_CNT_W'(cur_r_ff) + ROW_CNT_W'(1)) < nr;
            nb_idx = cur_idx_ff + CELL_W'(nc);
            nb_r   = cur_r_ff + ROW_W'(1);
         end
         DIR_LEFT: begin
            nb_inf = (cur_c_ff != '0);
            nb_idx = cur_idx_ff - CELL_W'(1);
            nb_c   = cur_c_ff - COL_W'(1);
         end
         DIR_RIGHT: begin
            nb_inf = (COL_CNT_W'(cur_c_ff) + COL_CNT_W'(1)) < nc;
            nb_idx = cur_idx_ff + CELL_W'(1);
            nb_c   = cur_c_ff + COL_W'(1);
         end
         default: begin
            nb_inf = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && !csr_acc && (load_cnt_ff + CNT_W'(1)) >= total) state_in = ST_SF_RD;
         end
         ST_SF_RD: begin
            state_in = ST_SF_CHK;
         end
         ST_SF_CHK: begin
            if (dir_ff != DIR_RIGHT) state_in = ST_SF_RD;
            else if (last_cell) state_in = ST_SEED_RD;
            else state_in = ST_SF_RD;
         end
         ST_SEED_RD: begin
            state_in = ST_SEED_CHK;
         end
         ST_SEED_CHK: begin
            state_in = last_row ? ST_POP : ST_SEED_RD;
         end
         ST_POP: begin
            if (head_ff == tail_ff) state_in = ST_DONE;
            else if (head_ff != lvl_end_ff) state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            state_in = ST_POP_MUL;
         end
         ST_POP_MUL: begin
            state_in = last_col ? ST_DONE : ST_NB_RD;
         end
         ST_NB_RD: begin
            if (nb_inf) state_in = ST_NB_CHK;
            else if (dir_ff == DIR_RIGHT) state_in = ST_POP;
         end
         ST_NB_CHK: begin
            state_in = (dir_ff == DIR_RIGHT) ? ST_POP : ST_NB_RD;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      load_cnt_in = load_cnt_ff;
      cur_r_in    = cur_r_ff;
      cur_c_in    = cur_c_ff;
      cur_idx_in  = cur_idx_ff;
      nb_r_in     = nb_r_ff;
      nb_c_in     = nb_c_ff;
      nb_idx_in   = nb_idx_ff;
      nb_ok_in    = nb_ok_ff;
      dir_in      = dir_ff;
      unsafe_in   = unsafe_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      lvl_end_in  = lvl_end_ff;
      level_in    = level_ff;
      found_in    = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_len_in   = rsp_len_ff;
      mine_we     = 1'b0;
      mine_raddr  = nb_idx;
      seen_we     = 1'b0;
      seen_waddr  = cur_idx_ff;
      seen_wdata  = 1'b1;
      seen_raddr  = cur_idx_ff;
      queue_we    = 1'b0;
      queue_waddr = tail_ff[CELL_W-1:0];
      queue_wdata = {cur_r_ff, COL_W'(0)};
      queue_raddr = head_ff[CELL_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               if (csr_index == CSR_ROWS) rows_in = csr_data;
               if (csr_index == CSR_COLS) cols_in = csr_data;
               load_cnt_in = '0;
            end else if (req_acc) begin
               mine_we = 1'b1;
               if ((load_cnt_ff + CNT_W'(1)) >= total) begin
                  load_cnt_in = '0;
                  cur_r_in    = '0;
                  cur_c_in    = '0;
                  cur_idx_in  = '0;
                  dir_in      = DIR_SELF;
                  unsafe_in   = 1'b0;
               end else begin
                  load_cnt_in = load_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_SF_RD: begin
            nb_ok_in = nb_inf;
         end
         ST_SF_CHK: begin
            if (dir_ff != DIR_RIGHT) begin
               unsafe_in = unsafe_now;
               dir_in    = dir_ff + DIR_W'(1);
            end else begin
               // unsafe cells are marked seen so the walk never enters them
               seen_we    = 1'b1;
               seen_waddr = cur_idx_ff;
               seen_wdata = unsafe_now;
               unsafe_in  = 1'b0;
               dir_in     = DIR_SELF;
               if (last_cell) begin
                  cur_r_in   = '0;
                  cur_c_in   = '0;
                  cur_idx_in = '0;
                  tail_in    = '0;
               end else begin
                  cur_idx_in = cur_idx_ff + CELL_W'(1);
                  if (last_col) begin
                     cur_c_in = '0;
                     cur_r_in = cur_r_ff + ROW_W'(1);
                  end else begin
                     cur_c_in = cur_c_ff + COL_W'(1);
                  end
               end
            end
         end
         ST_SEED_RD: begin
            seen_raddr = cur_idx_ff;
         end
         ST_SEED_CHK: begin
            if (!seen_rd_ff) begin
               seen_we    = 1'b1;
               seen_waddr = cur_idx_ff;
               queue_we   = 1'b1;
               tail_in    = tail_ff + CNT_W'(1);
            end
            cur_r_in   = cur_r_ff + ROW_W'(1);
            cur_idx_in = cur_idx_ff + CELL_W'(nc);
            if (last_row) begin
               lvl_end_in = tail_in;
               head_in    = '0;
               level_in   = '0;
            end
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               found_in = 1'b0;
            end else if (head_ff == lvl_end_ff) begin
               // level boundary
               lvl_end_in = tail_ff;
               level_in   = level_ff + LEN_W'(1);
            end else begin
               head_in = head_ff + CNT_W'(1);
            end
         end
         ST_POP_WAIT: begin
            cur_r_in = queue_rd_ff[ENTRY_W-1:COL_W];
            cur_c_in = queue_rd_ff[COL_W-1:0];
         end
         ST_POP_MUL: begin
            cur_idx_in = CELL_W'(CELL_W'(cur_r_ff) * CELL_W'(nc) + CELL_W'(cur_c_ff));
            dir_in     = DIR_UP;
            if (last_col) found_in = 1'b1;
         end
         ST_NB_RD: begin
            seen_raddr = nb_idx;
            nb_idx_in  = nb_idx;
            nb_r_in    = nb_r;
            nb_c_in    = nb_c;
            if (!nb_inf && dir_ff != DIR_RIGHT) dir_in = dir_ff + DIR_W'(1);
         end
         ST_NB_CHK: begin
            if (!seen_rd_ff && queue_room) begin
               seen_we     = 1'b1;
               seen_waddr  = nb_idx_ff;
               queue_we    = 1'b1;
               queue_wdata = {nb_r_ff, nb_c_ff};
               tail_in     = tail_ff + CNT_W'(1);
            end
            if (dir_ff != DIR_RIGHT) dir_in = dir_ff + DIR_W'(1);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_len_in   = found_ff ? level_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= CFG_W'(32);
         cols_ff      <= CFG_W'(32);
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cur_r_ff     <= cur_r_in;
      cur_c_ff     <= cur_c_in;
      cur_idx_ff   <= cur_idx_in;
      nb_r_ff      <= nb_r_in;
      nb_c_ff      <= nb_c_in;
      nb_idx_ff    <= nb_idx_in;
      nb_ok_ff     <= nb_ok_in;
      dir_ff       <= dir_in;
      unsafe_ff    <= unsafe_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      lvl_end_ff   <= lvl_end_in;
      level_ff     <= level_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_len_ff   <= rsp_len_in;
   end

   // Field memory
   always_ff @(posedge clock) begin
      if (mine_we) mine_mem[load_cnt_ff[CELL_W-1:0]] <= req_cell_open;
      mine_rd_ff <= mine_mem[mine_raddr];
   end

   // Visited map
   always_ff @(posedge clock) begin
      if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
      seen_rd_ff <= seen_mem[seen_raddr];
   end

   // Frontier queue
   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
      queue_rd_ff <= queue_mem[queue_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_route_found  = rsp_found_ff;
   assign rsp_route_length = rsp_len_ff;

endmodule
